// File: rtl/escaped_frame_receiver_assert.svh
// assertion macros for the escaped frame receiver checker
// no dependencies; taken in by the checker file only
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define EFR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define EFR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/efr_pkg.sv
// shared types and constants of the escaped frame receiver
// no dependencies; imported by every module of the block except efr_ram
`timescale 1ns / 1ps

package efr_pkg;

   // payload buffer geometry
   localparam int PAYLOAD_DEPTH = 128;
   localparam int PAYLOAD_AW    = $clog2(PAYLOAD_DEPTH);

   // field widths
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 8;
   localparam int FUNC_W  = 2;
   localparam int RUN_W   = 4;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_BYTE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

   // register map, index = byte address / 4
   typedef enum logic [2:0] {
      CSR_BEGIN_MARKER   = 3'd0,
      CSR_END_MARKER     = 3'd1,
      CSR_ESCAPE_MARKER  = 3'd2,
      CSR_ESCAPED_BEGIN  = 3'd3,
      CSR_ESCAPED_END    = 3'd4,
      CSR_ESCAPED_ESCAPE = 3'd5,
      CSR_SHORT_LIMIT    = 3'd6,
      CSR_CONFIRM_FRAMES = 3'd7
   } csr_index_type;

   // frame status as seen on the response
   typedef enum logic [1:0] {
      FRAME_IDLE = 2'd0,
      FRAME_RECV = 2'd1,
      FRAME_DONE = 2'd2
   } frame_state_type;

   // classified request kinds
   typedef enum logic [2:0] {
      OP_NOP,
      OP_BEGIN,
      OP_END,
      OP_ESCAPE,
      OP_DATA,
      OP_RELEASE,
      OP_READ
   } op_kind_type;

   // one classified request as it sits in the queue
   typedef struct packed {
      op_kind_type             kind;
      logic [BYTE_W-1:0]       raw;
      logic [BYTE_W-1:0]       mapped;
      logic                    esc_ok;
      logic [PAYLOAD_AW-1:0]   index;
   } op_type;

   // marker settings used by the classifier
   typedef struct packed {
      logic [BYTE_W-1:0] begin_marker;
      logic [BYTE_W-1:0] end_marker;
      logic [BYTE_W-1:0] escape_marker;
      logic [BYTE_W-1:0] escaped_begin;
      logic [BYTE_W-1:0] escaped_end;
      logic [BYTE_W-1:0] escaped_escape;
   } marker_cfg_type;

   // length learning settings used by the back end
   typedef struct packed {
      logic [BYTE_W-1:0] short_limit;
      logic [RUN_W-1:0]  confirm_frames;
   } learn_cfg_type;

endpackage

// File: rtl/efr_ram.sv
// generic simple dual port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module efr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/efr_csr.sv
// configuration registers of the escaped frame receiver, apb style access
// depends on efr_pkg
`timescale 1ns / 1ps

module efr_csr
   import efr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready,
   output marker_cfg_type      marker_cfg,
   output learn_cfg_type       learn_cfg
);

   marker_cfg_type marker_ff, marker_in;
   learn_cfg_type  learn_ff, learn_in;
   csr_index_type  csr_index;
   logic           wr_hit;
   logic [BYTE_W-1:0] wr_byte;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_AW-1:2]);
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign wr_byte    = csr_pwdata[BYTE_W-1:0];

   // register write decode
   always_comb begin
      marker_in = marker_ff;
      learn_in  = learn_ff;
      if (wr_hit) begin
         unique case (csr_index)
            CSR_BEGIN_MARKER:   marker_in.begin_marker   = wr_byte;
            CSR_END_MARKER:     marker_in.end_marker     = wr_byte;
            CSR_ESCAPE_MARKER:  marker_in.escape_marker  = wr_byte;
            CSR_ESCAPED_BEGIN:  marker_in.escaped_begin  = wr_byte;
            CSR_ESCAPED_END:    marker_in.escaped_end    = wr_byte;
            CSR_ESCAPED_ESCAPE: marker_in.escaped_escape = wr_byte;
            CSR_SHORT_LIMIT:    learn_in.short_limit     = wr_byte;
            CSR_CONFIRM_FRAMES: learn_in.confirm_frames  = csr_pwdata[RUN_W-1:0];
            default:            marker_in = marker_ff;
         endcase
      end
   end

   // register storage with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff.begin_marker   <= 8'd64;
         marker_ff.end_marker     <= 8'd13;
         marker_ff.escape_marker  <= 8'd10;
         marker_ff.escaped_begin  <= 8'd130;
         marker_ff.escaped_end    <= 8'd131;
         marker_ff.escaped_escape <= 8'd132;
         learn_ff.short_limit     <= 8'd74;
         learn_ff.confirm_frames  <= 4'd4;
      end else begin
         marker_ff <= marker_in;
         learn_ff  <= learn_in;
      end
   end

   // read mux
   always_comb begin
      unique case (csr_index)
         CSR_BEGIN_MARKER:   csr_prdata = CSR_DW'(marker_ff.begin_marker);
         CSR_END_MARKER:     csr_prdata = CSR_DW'(marker_ff.end_marker);
         CSR_ESCAPE_MARKER:  csr_prdata = CSR_DW'(marker_ff.escape_marker);
         CSR_ESCAPED_BEGIN:  csr_prdata = CSR_DW'(marker_ff.escaped_begin);
         CSR_ESCAPED_END:    csr_prdata = CSR_DW'(marker_ff.escaped_end);
         CSR_ESCAPED_ESCAPE: csr_prdata = CSR_DW'(marker_ff.escaped_escape);
         CSR_SHORT_LIMIT:    csr_prdata = CSR_DW'(learn_ff.short_limit);
         CSR_CONFIRM_FRAMES: csr_prdata = CSR_DW'(learn_ff.confirm_frames);
         default:            csr_prdata = '0;
      endcase
   end

   assign marker_cfg = marker_ff;
   assign learn_cfg  = learn_ff;

endmodule

// File: rtl/efr_front.sv
// front end: accepts requests, classifies bytes against the markers, queues them
// depends on efr_pkg
`timescale 1ns / 1ps

module efr_front
   import efr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [BYTE_W-1:0]       req_rx_byte,
   input  logic [PAYLOAD_AW-1:0]   req_read_index,
   input  marker_cfg_type          marker_cfg,
   output logic                    q_valid,
   output op_type                  q_head,
   input  logic                    q_pop
);

   op_type                queue_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   op_type                op;
   logic                  push;
   logic                  pop;

   // classify: begin, then end, then escape, else payload; release and read by function code
   always_comb begin
      op.raw    = req_rx_byte;
      op.index  = req_read_index;
      op.mapped = req_rx_byte;
      op.esc_ok = 1'b1;
      if (req_rx_byte == marker_cfg.escaped_begin) begin
         op.mapped = marker_cfg.begin_marker;
      end else if (req_rx_byte == marker_cfg.escaped_end) begin
         op.mapped = marker_cfg.end_marker;
      end else if (req_rx_byte == marker_cfg.escaped_escape) begin
         op.mapped = marker_cfg.escape_marker;
      end else begin
         op.esc_ok = 1'b0;
      end
      unique case (req_func)
         FUNC_BYTE: begin
            if (req_rx_byte == marker_cfg.begin_marker) begin
               op.kind = OP_BEGIN;
            end else if (req_rx_byte == marker_cfg.end_marker) begin
               op.kind = OP_END;
            end else if (req_rx_byte == marker_cfg.escape_marker) begin
               op.kind = OP_ESCAPE;
            end else begin
               op.kind = OP_DATA;
            end
         end
         FUNC_RELEASE: op.kind = OP_RELEASE;
         FUNC_READ:    op.kind = OP_READ;
         default:      op.kind = OP_NOP;
      endcase
   end

   // queue handshake
   assign req_stall = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_head    = queue_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= op;
      end
   end

endmodule

// File: rtl/efr_back.sv
// back end: frame state, length learning, payload buffer and response register
// depends on efr_pkg and efr_ram
`timescale 1ns / 1ps

module efr_back
   import efr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  learn_cfg_type           learn_cfg,
   input  logic                    q_valid,
   input  op_type                  q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_frame_status,
   output logic [COUNT_W-1:0]      rsp_fill_count,
   output logic [COUNT_W-1:0]      rsp_learned_length,
   output logic                    rsp_short_frame,
   output logic [BYTE_W-1:0]       rsp_read_data
);

   frame_state_type      frame_ff, frame_in;
   logic [COUNT_W-1:0]   wpos_ff, wpos_in;
   logic                 esc_ff, esc_in;
   logic [COUNT_W-1:0]   exp_ff, exp_in;
   logic [RUN_W-1:0]     run_ff, run_in;
   logic                 short_ff, short_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   frame_state_type      rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_fill_ff;
   logic [COUNT_W-1:0]   rsp_learned_ff;
   logic                 rsp_short_ff;
   logic                 rd_sel_ff;

   logic                 take;
   logic                 busy;
   logic                 run_open;
   logic                 len_eq;
   logic                 esc_abort;
   logic                 overflow;
   logic [BYTE_W-1:0]    store_byte;
   logic                 wr_en;
   logic                 rd_en;
   logic [BYTE_W-1:0]    ram_rd_data;

   // shared decode of the queue head
   assign take       = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop      = take;
   assign busy       = (frame_ff == FRAME_DONE);
   assign run_open   = (run_ff < learn_cfg.confirm_frames);
   assign len_eq     = (wpos_ff == exp_ff);
   assign esc_abort  = esc_ff && !q_head.esc_ok;
   assign overflow   = (wpos_ff >= COUNT_W'(PAYLOAD_DEPTH));
   assign store_byte = esc_ff ? q_head.mapped : q_head.raw;

   // frame state next value
   always_comb begin
      frame_in = frame_ff;
      if (take) begin
         unique case (q_head.kind)
            OP_BEGIN: begin
               if (!busy) frame_in = FRAME_RECV;
            end
            OP_END: begin
               if (!busy) begin
                  if (run_open) frame_in = FRAME_IDLE;
                  else if (len_eq) frame_in = FRAME_DONE;
               end
            end
            OP_DATA: begin
               if (!busy && (esc_abort || overflow)) frame_in = FRAME_IDLE;
            end
            OP_RELEASE: begin
               if (busy) frame_in = FRAME_IDLE;
            end
            default: frame_in = frame_ff;
         endcase
      end
   end

   // counters, learning and buffer access
   always_comb begin
      wpos_in  = wpos_ff;
      esc_in   = esc_ff;
      exp_in   = exp_ff;
      run_in   = run_ff;
      short_in = short_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      if (take) begin
         unique case (q_head.kind)
            OP_BEGIN: begin
               if (!busy) begin
                  wpos_in = '0;
                  esc_in  = 1'b0;
               end
            end
            OP_END: begin
               if (!busy && run_open) begin
                  if (len_eq) begin
                     run_in = run_ff + 1'b1;
                     if (exp_ff < learn_cfg.short_limit) short_in = 1'b1;
                  end else begin
                     run_in = '0;
                     exp_in = wpos_ff;
                  end
               end
            end
            OP_ESCAPE: begin
               if (!busy) esc_in = 1'b1;
            end
            OP_DATA: begin
               if (!busy) begin
                  esc_in = 1'b0;
                  if (!esc_abort && !overflow) begin
                     wr_en   = 1'b1;
                     wpos_in = wpos_ff + 1'b1;
                  end
               end
            end
            OP_READ: rd_en = 1'b1;
            default: rd_en = 1'b0;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= FRAME_IDLE;
         wpos_ff      <= '0;
         esc_ff       <= 1'b0;
         exp_ff       <= COUNT_W'(PAYLOAD_DEPTH);
         run_ff       <= '0;
         short_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_ff     <= frame_in;
         wpos_ff      <= wpos_in;
         esc_ff       <= esc_in;
         exp_ff       <= exp_in;
         run_ff       <= run_in;
         short_ff     <= short_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response register, loaded with the updated state
   assign rsp_valid_in = take || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_status_ff  <= frame_in;
         rsp_fill_ff    <= wpos_in;
         rsp_learned_ff <= exp_in;
         rsp_short_ff   <= short_in;
         rd_sel_ff      <= (q_head.kind == OP_READ);
      end
   end

   // payload buffer
   efr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_efr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wpos_ff[PAYLOAD_AW-1:0]),
      .wr_data (store_byte),
      .rd_en   (rd_en),
      .rd_addr (q_head.index),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_frame_status   = rsp_status_ff;
   assign rsp_fill_count     = rsp_fill_ff;
   assign rsp_learned_length = rsp_learned_ff;
   assign rsp_short_frame    = rsp_short_ff;
   assign rsp_read_data      = rd_sel_ff ? ram_rd_data : '0;

endmodule

// File: rtl/escaped_frame_receiver.sv
// path: an accepted request goes into the front queue, then the back end loads the response register
// throughput: one request per cycle unless stalled; the front queue takes requests while the
// response register waits, the back end handles one queued request per cycle while not stalled
// reset: synchronous, clears frame state, learning counters, queue, registers
// to their defaults; the payload buffer is not cleared and holds old data
`timescale 1ns / 1ps

module escaped_frame_receiver
   import efr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [FUNC_W-1:0]       req_func,
   input  logic [BYTE_W-1:0]       req_rx_byte,
   input  logic [PAYLOAD_AW-1:0]   req_read_index,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_frame_status,
   output logic [COUNT_W-1:0]      rsp_fill_count,
   output logic [COUNT_W-1:0]      rsp_learned_length,
   output logic                    rsp_short_frame,
   output logic [BYTE_W-1:0]       rsp_read_data,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_AW-1:0]       csr_paddr,
   input  logic [CSR_DW-1:0]       csr_pwdata,
   output logic [CSR_DW-1:0]       csr_prdata,
   output logic                    csr_pready
);

   marker_cfg_type marker_cfg;
   learn_cfg_type  learn_cfg;
   logic           q_valid;
   op_type         q_head;
   logic           q_pop;

   // configuration registers
   efr_csr u_efr_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .marker_cfg  (marker_cfg),
      .learn_cfg   (learn_cfg)
   );

   // request intake and classification
   efr_front u_efr_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_rx_byte    (req_rx_byte),
      .req_read_index (req_read_index),
      .marker_cfg     (marker_cfg),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop)
   );

   // frame handling and responses
   efr_back u_efr_back (
      .clock              (clock),
      .reset              (reset),
      .learn_cfg          (learn_cfg),
      .q_valid            (q_valid),
      .q_head             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_fill_count     (rsp_fill_count),
      .rsp_learned_length (rsp_learned_length),
      .rsp_short_frame    (rsp_short_frame),
      .rsp_read_data      (rsp_read_data)
   );

endmodule

// File: rtl/efr_checker.sv
// port level checks of the escaped frame receiver, bound to the top level
// depends on efr_pkg and escaped_frame_receiver_assert.svh
`timescale 1ns / 1ps
`include "escaped_frame_receiver_assert.svh"

module efr_checker
   import efr_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [1:0]           rsp_frame_status,
   input logic [COUNT_W-1:0]   rsp_fill_count,
   input logic [COUNT_W-1:0]   rsp_learned_length,
   input logic                 rsp_short_frame
);

   // a stalled response stays offered
   `EFR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")

   // an accepted frame always has the learned length
   `EFR_ASSERT_IMP(a_done_len, clock, reset, rsp_valid && (rsp_frame_status == FRAME_DONE), rsp_fill_count == rsp_learned_length, "accepted frame length mismatch")

   // fill count never passes the buffer size
   `EFR_ASSERT_IMP(a_fill_max, clock, reset, rsp_valid, rsp_fill_count <= COUNT_W'(PAYLOAD_DEPTH), "fill count beyond buffer")

   // short frame flag is sticky until reset
   `EFR_ASSERT_NXT(a_short_sticky, clock, reset, rsp_valid && rsp_short_frame, rsp_short_frame, "short frame flag cleared")

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (.*);
